// File: src/dth_pkg.sv
package dth_pkg;

    // APB address width: one 32-bit register at byte address 0.
    localparam int CFG_ADDR_W = 3;

    // Register index, taken from the word address of the APB port.
    localparam logic REG_BUFFER_LENGTH = 1'b0;

    // Constants of the DER encoding.
    localparam logic [7:0] HIGH_TAG_MASK = 8'h1f;
    localparam logic [7:0] LONG_FORM_BIT = 8'h80;
    localparam logic [6:0] LEN_COUNT_MASK = 7'h7f;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_HIGH_TAG     = 3'd1,
        ST_INDEFINITE   = 3'd2,
        ST_LEN_TOO_LONG = 3'd3,
        ST_LEADING_ZERO = 3'd4,
        ST_NONMINIMAL   = 3'd5,
        ST_OVERFLOW     = 3'd6,
        ST_TRUNCATED    = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        PH_IDENT     = 4'b0001,
        PH_LEN_FIRST = 4'b0010,
        PH_LEN_LONG  = 4'b0100,
        PH_SKIP      = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] length;
        logic [31:0] value_offset;
        status_t     status;
    } out_word_t;

endpackage

// File: src/dth_cfg_regs.sv
module dth_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dth_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic [31:0]                    buffer_length
);
    import dth_pkg::*;

    logic [31:0] buf_len_reg;
    logic [31:0] buf_len_next;
    logic        reg_index;

    // Word address of the access; byte offsets inside the word are ignored.
    assign reg_index = paddr[CFG_ADDR_W-1];

    always_comb
    begin
        buf_len_next = buf_len_reg;
        if (psel && penable && pwrite && (reg_index == REG_BUFFER_LENGTH))
        begin
            buf_len_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_len_reg <= '0;
        end
        else
        begin
            buf_len_reg <= buf_len_next;
        end
    end

    assign prdata        = (reg_index == REG_BUFFER_LENGTH) ? buf_len_reg : '0;
    assign buffer_length = buf_len_reg;

endmodule

// File: src/dth_parse_core.sv
module dth_parse_core #(
    parameter int MAX_LENGTH_OCTETS = 4,
    parameter int POSITION_BITS     = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  dth_pkg::in_word_t  in_word,
    input  logic [31:0]        buffer_length,
    output logic               res_valid,
    output dth_pkg::out_word_t res_word
);
    import dth_pkg::*;

    localparam int EW = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam int SW = ((POSITION_BITS > 33) ? POSITION_BITS : 33) + 1;
    localparam int LW = $clog2(MAX_LENGTH_OCTETS + 1);
    localparam logic [6:0] MAX_OCTETS_C = 7'(MAX_LENGTH_OCTETS);
    localparam logic [32:0] LEN_SAT = 33'h1_0000_0000;

    phase_t                   phase_reg, phase_next, phase_c;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, pos_c;
    logic [7:0]               tag_reg, tag_next;
    logic [32:0]              acc_reg, acc_next, acc_c;
    logic [LW-1:0]            left_reg, left_next, left_c;
    logic                     first_reg, first_next, first_c;
    logic [31:0]              skip_reg, skip_next, skip_c;
    logic                     err_reg, err_next, err_c;

    logic [EW-1:0]  end_eff;
    logic           ignore;
    logic           more;
    logic [7:0]     b;
    logic [40:0]    acc_wide;
    logic [32:0]    acc_shift;
    logic [LW-1:0]  left_dec;
    logic [32:0]    fin_len;
    logic           overflow;
    logic [SW-1:0]  voff;

    assign b = in_word.data_byte;

    // A start mark clears the position, phase, length and skip state and the
    // error latch first; the same byte is then parsed as the first byte of the buffer.
    always_comb
    begin
        if (in_word.start_req)
        begin
            phase_c = PH_IDENT;
            pos_c   = '0;
            acc_c   = '0;
            left_c  = '0;
            first_c = 1'b1;
            skip_c  = '0;
            err_c   = 1'b0;
        end
        else
        begin
            phase_c = phase_reg;
            pos_c   = pos_reg;
            acc_c   = acc_reg;
            left_c  = left_reg;
            first_c = first_reg;
            skip_c  = skip_reg;
            err_c   = err_reg;
        end
    end

    // The buffer end is the lower of the register and the largest position.
    always_comb
    begin
        if (EW'(buffer_length) < EW'({POSITION_BITS{1'b1}}))
        begin
            end_eff = EW'(buffer_length);
        end
        else
        begin
            end_eff = EW'({POSITION_BITS{1'b1}});
        end
    end

    assign ignore = err_c || (EW'(pos_c) >= end_eff);
    assign more   = (SW'(pos_c) + SW'(1)) < SW'(end_eff);
    assign voff   = SW'(pos_c) + SW'(1);

    // Long-form accumulation saturates just above 32 bits.
    assign acc_wide  = {acc_c, 8'h00} | 41'(b);
    assign acc_shift = (|acc_wide[40:32]) ? LEN_SAT : acc_wide[32:0];
    assign left_dec  = (left_c != '0) ? (left_c - LW'(1)) : left_c;

    assign fin_len  = (phase_c == PH_LEN_FIRST) ? 33'(b) : acc_shift;
    // The value overruns the buffer when voff + len > end, i.e. len + pos >= end.
    assign overflow = (SW'(fin_len) + SW'(pos_c)) >= SW'(end_eff);

    always_comb
    begin
        phase_next = phase_c;
        pos_next   = pos_c;
        tag_next   = tag_reg;
        acc_next   = acc_c;
        left_next  = left_c;
        first_next = first_c;
        skip_next  = skip_c;
        err_next   = err_c;

        res_valid             = 1'b0;
        res_word.tag          = tag_reg;
        res_word.length       = '0;
        res_word.value_offset = '0;
        res_word.status       = ST_OK;

        if (!ignore)
        begin
            pos_next = pos_c + POSITION_BITS'(1);
            unique case (phase_c)
                PH_IDENT:
                begin
                    tag_next     = b;
                    res_word.tag = b;
                    if ((b & HIGH_TAG_MASK) == HIGH_TAG_MASK)
                    begin
                        res_valid       = 1'b1;
                        res_word.status = ST_HIGH_TAG;
                    end
                    else if (!more)
                    begin
                        res_valid       = 1'b1;
                        res_word.status = ST_TRUNCATED;
                    end
                    else
                    begin
                        phase_next = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST:
                begin
                    if ((b & LONG_FORM_BIT) == 8'h00)
                    begin
                        res_valid = 1'b1;
                        if (overflow)
                        begin
                            res_word.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            res_word.length       = 32'(b);
                            res_word.value_offset = voff[31:0];
                            skip_next             = 32'(b);
                            phase_next            = (b != 8'h00) ? PH_SKIP : PH_IDENT;
                        end
                    end
                    else if ((b[6:0] & LEN_COUNT_MASK) == 7'd0)
                    begin
                        res_valid       = 1'b1;
                        res_word.status = ST_INDEFINITE;
                    end
                    else if (b[6:0] > MAX_OCTETS_C)
                    begin
                        res_valid       = 1'b1;
                        res_word.status = ST_LEN_TOO_LONG;
                    end
                    else
                    begin
                        left_next  = b[LW-1:0];
                        acc_next   = '0;
                        first_next = 1'b1;
                        if (!more)
                        begin
                            res_valid       = 1'b1;
                            res_word.status = ST_TRUNCATED;
                        end
                        else
                        begin
                            phase_next = PH_LEN_LONG;
                        end
                    end
                end
                PH_LEN_LONG:
                begin
                    if (first_c && (b == 8'h00))
                    begin
                        res_valid       = 1'b1;
                        res_word.status = ST_LEADING_ZERO;
                    end
                    else
                    begin
                        first_next = 1'b0;
                        acc_next   = acc_shift;
                        left_next  = left_dec;
                        if (left_dec == '0)
                        begin
                            res_valid = 1'b1;
                            if (acc_shift < 33'(LONG_FORM_BIT))
                            begin
                                res_word.status = ST_NONMINIMAL;
                            end
                            else if (overflow)
                            begin
                                res_word.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                // Minimal long form is at least 128, never zero.
                                res_word.length       = acc_shift[31:0];
                                res_word.value_offset = voff[31:0];
                                skip_next             = acc_shift[31:0];
                                phase_next            = PH_SKIP;
                            end
                        end
                        else if (!more)
                        begin
                            res_valid       = 1'b1;
                            res_word.status = ST_TRUNCATED;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = (skip_c != '0) ? (skip_c - 32'd1) : skip_c;
                    if (skip_next == '0)
                    begin
                        phase_next = PH_IDENT;
                    end
                end
                default:
                begin
                    phase_next = PH_IDENT;
                end
            endcase

            if (res_valid && (res_word.status != ST_OK))
            begin
                err_next   = 1'b1;
                phase_next = PH_IDENT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDENT;
            pos_reg   <= '0;
            tag_reg   <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
            first_reg <= 1'b1;
            skip_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tag_reg   <= tag_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            first_reg <= first_next;
            skip_reg  <= skip_next;
            err_reg   <= err_next;
        end
    end

    a_err_latches: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && (res_word.status != ST_OK) |=> err_reg)
        else $error("error result did not latch the error flag");

    a_quiet_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        step && err_reg && !in_word.start_req |-> !res_valid)
        else $error("result produced while an error is latched");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && (res_word.status == ST_OK) && (res_word.length == '0)
        |=> (phase_reg == PH_IDENT))
        else $error("zero-length value did not return to the identifier phase");

    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && (res_word.status != ST_OK) |=> (phase_reg == PH_IDENT))
        else $error("error result left the parser outside the identifier phase");

endmodule

// File: src/der_tlv_header_parser.sv
// A byte accepted into the input register passes through the parse logic into the
// result register, which drives the output. Throughput: one byte per cycle unless
// the output stalls; during a stall only an empty input register takes a new word.
// Reset (rst_n, asynchronous, active low) empties both registers, sets the parser
// to expect an identifier octet at position 0 and clears buffer_length to 0.
module der_tlv_header_parser #(
    parameter int MAX_LENGTH_OCTETS = 4,
    parameter int POSITION_BITS     = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Byte stream in.
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dth_pkg::in_word_t              in_word,
    // Header results out.
    output logic                           out_valid,
    input  logic                           out_ready,
    output dth_pkg::out_word_t             out_word,
    // APB configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dth_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import dth_pkg::*;

    // The block is a two-register pipeline. The input register holds one byte
    // word and the start mark; the parse core turns it, together with the
    // parser state, into zero or one result word combinationally; the result
    // register holds that word until the consumer takes it. Parser state only
    // advances when the input register moves into the parse stage, so a stall
    // on the output side freezes the whole parse in place.

    logic        s1_valid_reg, s1_valid_next;
    in_word_t    s1_word_reg, s1_word_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_word_reg, out_word_next;

    logic        advance;
    logic        res_valid;
    out_word_t   res_word;
    logic [31:0] buffer_length;

    // The parse stage moves whenever the result register is free or is
    // being emptied in this cycle; bytes that give no result move the same way.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    dth_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .buffer_length (buffer_length)
    );

    dth_parse_core #(
        .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS),
        .POSITION_BITS     (POSITION_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .in_word       (s1_word_reg),
        .buffer_length (buffer_length),
        .res_valid     (res_valid),
        .res_word      (res_word)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_word_next  = s1_word_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
            s1_word_next  = in_word;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res_word;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags guard them.
    always_ff @(posedge clk)
    begin
        s1_word_reg  <= s1_word_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign pready    = 1'b1;

endmodule
